>>> rtl/id3_pkg.sv
// ----------------------------------------------------------------------------
// ID3v2 tag frame parser package
// Shared types, codes and the frame id table of the tag frame parser.
// ----------------------------------------------------------------------------
package id3_pkg;

	// Parser phases: tag header, frame id, frame size, frame flags, frame body, done.
	typedef enum logic [2:0] {
		PH_HEADER,
		PH_FID,
		PH_FSIZE,
		PH_FFLAGS,
		PH_BODY,
		PH_DONE
	} id3_phase_t;

	// Walk through the head of a picture frame before its image data.
	typedef enum logic [2:0] {
		PIC_ENC,
		PIC_MIME,
		PIC_TYPE,
		PIC_DESC,
		PIC_DATA
	} id3_pic_t;

	// Result kinds.
	localparam logic [3:0] KIND_VER_MAJOR = 4'd0;
	localparam logic [3:0] KIND_VER_MINOR = 4'd1;
	localparam logic [3:0] KIND_IMAGE     = 4'd10;
	localparam logic [3:0] KIND_SKIP      = 4'd15;

	localparam int unsigned NUM_IDS = 10;

	// Known frame ids and the kind that each one maps to.
	localparam logic [31:0] KNOWN_IDS [NUM_IDS] = '{
		32'h54504531, 32'h54495432, 32'h54414C42, 32'h54434F4E, 32'h54594552,
		32'h54524143, 32'h5442504D, 32'h54505542, 32'h5452434B, 32'h41504943
	};
	localparam logic [3:0] KNOWN_KINDS [NUM_IDS] = '{
		4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd7, 4'd10
	};

	typedef struct packed {
		id3_phase_t  phase;
		logic [3:0]  field_count;
		logic [27:0] tag_left;
		logic [31:0] frame_id_shift;
		logic [31:0] frame_left;
		logic [3:0]  frame_kind;
		id3_pic_t    picture_substate;
	} id3_state_t;

	localparam id3_state_t STATE_RESET = '{
		phase:            PH_HEADER,
		field_count:      4'd0,
		tag_left:         28'd0,
		frame_id_shift:   32'd0,
		frame_left:       32'd0,
		frame_kind:       4'd0,
		picture_substate: PIC_ENC
	};

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] value_byte;
		logic       last;
	} id3_result_t;

	// Maps a frame id to its kind; unknown ids are skipped.
	function automatic logic [3:0] lookup_kind(input logic [31:0] id);
		logic [3:0] k;
		k = KIND_SKIP;
		for (int i = 0; i < NUM_IDS; i++) begin
			if (KNOWN_IDS[i] == id) begin
				k = KNOWN_KINDS[i];
			end
		end
		return k;
	endfunction

endpackage

>>> rtl/id3_in_stage.sv
// ----------------------------------------------------------------------------
// ID3 input stage
// Registers one incoming tag byte and its start flag until it is processed.
// ----------------------------------------------------------------------------
module id3_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       in_start,
	input  logic [7:0] in_byte,
	input  logic       take,
	output logic       valid_s1,
	output logic       start_s1,
	output logic [7:0] byte_s1
);

	// The stage refills in the same cycle that its byte is taken.
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			start_s1 <= in_start;
			byte_s1  <= in_byte;
		end
	end

endmodule

>>> rtl/id3_step.sv
// ----------------------------------------------------------------------------
// ID3 parse step
// Combinational next state and result for one tag byte.
// ----------------------------------------------------------------------------
module id3_step (
	input  id3_pkg::id3_state_t  cur_st,
	input  logic                 start,
	input  logic [7:0]           data_byte,
	output id3_pkg::id3_state_t  nxt_st,
	output logic                 res_valid,
	output id3_pkg::id3_result_t res
);

	id3_pkg::id3_state_t st;
	logic [3:0]  fc_inc;
	logic [31:0] fid_new;
	logic [31:0] fsize_new;
	logic [31:0] fl_dec;

	// A start byte parses as if the block had just come out of reset.
	assign st        = start ? id3_pkg::STATE_RESET : cur_st;
	assign fc_inc    = st.field_count + 4'd1;
	assign fid_new   = {st.frame_id_shift[23:0], data_byte};
	assign fsize_new = {st.frame_left[23:0], data_byte};
	assign fl_dec    = st.frame_left - 32'd1;

	always_comb begin : next_state_logic
		nxt_st = st;
		case (st.phase)
			id3_pkg::PH_HEADER: begin
				nxt_st.field_count = fc_inc;
				if (st.field_count >= 4'd6) begin
					nxt_st.tag_left = {st.tag_left[20:0], data_byte[6:0]};
				end
				if (fc_inc >= 4'd10) begin
					nxt_st.phase          = id3_pkg::PH_FID;
					nxt_st.field_count    = 4'd0;
					nxt_st.frame_id_shift = 32'd0;
					nxt_st.frame_left     = 32'd0;
					if (nxt_st.tag_left == 28'd0) begin
						nxt_st.phase = id3_pkg::PH_DONE;
					end
				end
			end
			id3_pkg::PH_DONE: begin
				nxt_st = st;
			end
			default: begin
				nxt_st.tag_left = st.tag_left - 28'd1;
				case (st.phase)
					id3_pkg::PH_FID: begin
						nxt_st.frame_id_shift = fid_new;
						nxt_st.field_count    = fc_inc;
						if (fc_inc >= 4'd4) begin
							if (fid_new == 32'd0) begin
								// Padding ends the tag.
								nxt_st.phase = id3_pkg::PH_DONE;
							end else begin
								nxt_st.frame_kind  = id3_pkg::lookup_kind(fid_new);
								nxt_st.phase       = id3_pkg::PH_FSIZE;
								nxt_st.field_count = 4'd0;
							end
						end
					end
					id3_pkg::PH_FSIZE: begin
						nxt_st.frame_left  = fsize_new;
						nxt_st.field_count = fc_inc;
						if (fc_inc >= 4'd4) begin
							nxt_st.phase       = id3_pkg::PH_FFLAGS;
							nxt_st.field_count = 4'd0;
						end
					end
					id3_pkg::PH_FFLAGS: begin
						nxt_st.field_count = fc_inc;
						if (fc_inc >= 4'd2) begin
							nxt_st.picture_substate = id3_pkg::PIC_ENC;
							if (st.frame_left == 32'd0) begin
								nxt_st.phase          = id3_pkg::PH_FID;
								nxt_st.field_count    = 4'd0;
								nxt_st.frame_id_shift = 32'd0;
								nxt_st.frame_left     = 32'd0;
							end else begin
								nxt_st.phase       = id3_pkg::PH_BODY;
								nxt_st.field_count = 4'd0;
							end
						end
					end
					default: begin
						nxt_st.frame_left = fl_dec;
						if (st.frame_kind == id3_pkg::KIND_IMAGE) begin
							case (st.picture_substate)
								id3_pkg::PIC_ENC: nxt_st.picture_substate = id3_pkg::PIC_MIME;
								id3_pkg::PIC_MIME: begin
									if (data_byte == 8'd0) begin
										nxt_st.picture_substate = id3_pkg::PIC_TYPE;
									end
								end
								id3_pkg::PIC_TYPE: nxt_st.picture_substate = id3_pkg::PIC_DESC;
								id3_pkg::PIC_DESC: begin
									if (data_byte == 8'd0) begin
										nxt_st.picture_substate = id3_pkg::PIC_DATA;
									end
								end
								default: nxt_st.picture_substate = st.picture_substate;
							endcase
						end
						if (fl_dec == 32'd0) begin
							nxt_st.phase          = id3_pkg::PH_FID;
							nxt_st.field_count    = 4'd0;
							nxt_st.frame_id_shift = 32'd0;
							nxt_st.frame_left     = 32'd0;
						end
					end
				endcase
				if (nxt_st.tag_left == 28'd0) begin
					nxt_st.phase = id3_pkg::PH_DONE;
				end
			end
		endcase
	end

	always_comb begin : output_logic
		res_valid      = 1'b0;
		res.kind       = st.frame_kind;
		res.value_byte = data_byte;
		res.last       = (st.frame_left == 32'd1) || (st.tag_left == 28'd1);
		case (st.phase)
			id3_pkg::PH_HEADER: begin
				res.last = 1'b1;
				if (st.field_count == 4'd3) begin
					res_valid = 1'b1;
					res.kind  = id3_pkg::KIND_VER_MAJOR;
				end else if (st.field_count == 4'd4) begin
					res_valid = 1'b1;
					res.kind  = id3_pkg::KIND_VER_MINOR;
				end
			end
			id3_pkg::PH_BODY: begin
				if (st.frame_kind == id3_pkg::KIND_IMAGE) begin
					res_valid = !(st.picture_substate inside {id3_pkg::PIC_ENC,
						id3_pkg::PIC_MIME, id3_pkg::PIC_TYPE, id3_pkg::PIC_DESC});
				end else begin
					res_valid = (st.frame_kind != id3_pkg::KIND_SKIP);
				end
			end
			default: res_valid = 1'b0;
		endcase
	end

endmodule

>>> rtl/id3_out_buf.sv
// ----------------------------------------------------------------------------
// ID3 output buffer
// Two-entry result buffer that decouples the parse step from the consumer.
// ----------------------------------------------------------------------------
module id3_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  id3_pkg::id3_result_t push_data,
	output logic                 full,
	output logic                 out_valid,
	input  logic                 out_ready,
	output id3_pkg::id3_result_t out_data
);

	id3_pkg::id3_result_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/id3v2_tag_frame_parser_core.sv
// ----------------------------------------------------------------------------
// ID3v2 tag frame parser core
// Parses an ID3v2 tag one byte per request and emits version bytes, text
// frame payload bytes and picture data bytes tagged with their kind.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | tdata            | tuser        | tlast
//  ---------+-----------+------------------+--------------+-------------------
//  s_*      | in        | [7:0] data_byte  | [0] start_req| -
//  m_*      | out       | [7:0] value_byte | [3:0] kind   | last of the frame or tag, or a version byte
//
// Each input request is held in the input register and is resolved by one
// pass of the parse step, so a new byte is accepted every cycle while the
// output buffer has room. A result is written to the output buffer at the
// edge that takes its byte out of the input register, and the m_ side takes
// it from that buffer. Reset puts the parser at tag header byte 0 and
// empties both buffers. A stalled consumer fills the two-entry output
// buffer, and only then does s_tready drop; bytes that give no result still
// need buffer room.
//
module id3v2_tag_frame_parser_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic [0:0] s_tuser,   // [0] start_req
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] value_byte
	output logic [3:0] m_tuser,   // [3:0] kind
	output logic       m_tlast
);

	logic       valid_s1;
	logic       start_s1;
	logic [7:0] byte_s1;
	logic       buf_full;
	logic       fire;

	id3_pkg::id3_state_t  state_q;
	id3_pkg::id3_state_t  state_nxt;
	logic                 res_valid;
	id3_pkg::id3_result_t res;
	id3_pkg::id3_result_t out_res;

	// The byte in the input register is parsed whenever the output buffer
	// has room, whether or not that byte produces a result.
	assign fire = valid_s1 && !buf_full;

	id3_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_start (s_tuser[0]),
		.in_byte  (s_tdata),
		.take     (fire),
		.valid_s1 (valid_s1),
		.start_s1 (start_s1),
		.byte_s1  (byte_s1)
	);

	id3_step u_step (
		.cur_st    (state_q),
		.start     (start_s1),
		.data_byte (byte_s1),
		.nxt_st    (state_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	// Parser state advances only on a processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= id3_pkg::STATE_RESET;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	id3_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire && res_valid),
		.push_data (res),
		.full      (buf_full),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = out_res.value_byte;
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last;

endmodule
